// ----- rtl/ctce_pkg.sv -----
// ----------------------------------------------------------------------------
// ctce_pkg
// Shared types and constants of the columnar transposition encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package ctce_pkg;

    localparam int MAX_TEXT_DEF = 128;
    localparam int MAX_KEY_DEF  = 10;

    // key characters held in the two key registers
    localparam int KEY_CHARS    = 10;
    localparam int KEY_LOW_W    = 64;
    localparam int KEY_HIGH_W   = 16;
    localparam int KEY_LEN_W    = 4;
    localparam int KEY_W        = KEY_LOW_W + KEY_HIGH_W;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN  = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h24;

    typedef logic [7:0] key_char_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANK,
        ST_READ
    } ctce_state_t;

endpackage

`default_nettype wire

// ----- rtl/ctce_ram.sv -----
// ----------------------------------------------------------------------------
// ctce_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire                     aclk,
    input  wire                     wr_en,
    input  wire [$clog2(DEPTH)-1:0] wr_addr,
    input  wire [WIDTH-1:0]         wr_data,
    input  wire                     rd_en,
    input  wire [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctce_rank.sv -----
// ----------------------------------------------------------------------------
// ctce_rank
// Rank of one key column in a stable ascending sort of the key characters.
// ----------------------------------------------------------------------------
`default_nettype none

module ctce_rank #(
    parameter int MAX_KEY = ctce_pkg::MAX_KEY_DEF
) (
    input  ctce_pkg::key_char_t          key_chars [MAX_KEY],
    input  wire [$clog2(MAX_KEY+1)-1:0]  key_len,
    input  wire [$clog2(MAX_KEY)-1:0]    col,
    output logic [$clog2(MAX_KEY)-1:0]   rank
);

    import ctce_pkg::*;

    localparam int KI_W = $clog2(MAX_KEY);
    localparam int W_W  = $clog2(MAX_KEY+1);

    key_char_t          kc;
    logic [MAX_KEY-1:0] ahead;

    assign kc = key_chars[col];

    // one comparator per key position, ties broken by position
    always_comb begin
        for (int j = 0; j < MAX_KEY; j++) begin
            ahead[j] = (W_W'(j) < key_len) &&
                       ((key_chars[j] < kc) ||
                        ((key_chars[j] == kc) && (KI_W'(j) < col)));
        end
    end

    always_comb begin
        rank = '0;
        for (int j = 0; j < MAX_KEY; j++) begin
            rank = rank + KI_W'(ahead[j]);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/columnar_transposition_encrypt.sv -----
// ----------------------------------------------------------------------------
// columnar_transposition_encrypt
// Columnar transposition encryptor: stores plaintext in a RAM, sorts the key
// columns when the message closes and streams the ciphertext column by column.
// ----------------------------------------------------------------------------
//  channel  direction  tdata         tuser          tlast
//  s_       in         plain_byte    func           end_of_text
//  m_       out        cipher_byte   nothing_left   final_byte
//  cfg_     in         write data    -              -  (cfg_index selects)
//
//  a load writes the text RAM; a fetch reads it, then passes through ST_READ to the result register
//  a load with end_of_text starts the rank sweep over the key columns in ST_RANK
//  a fetch with nothing pending is answered in the cycle after it is taken
//  reset is synchronous; the RAM contents are not cleared
//  s_tready drops while the result register holds an untaken result
// ----------------------------------------------------------------------------
`default_nettype none

module columnar_transposition_encrypt #(
    parameter int MAX_TEXT = ctce_pkg::MAX_TEXT_DEF,
    parameter int MAX_KEY  = ctce_pkg::MAX_KEY_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,

    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [7:0]                          s_tdata,   // [7:0] plain_byte
    input  wire                                s_tuser,   // [0] func
    input  wire                                s_tlast,   // end_of_text

    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] cipher_byte
    output logic                               m_tuser,   // [0] nothing_left
    output logic                               m_tlast,   // final_byte

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [ctce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [ctce_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import ctce_pkg::*;

    localparam int AW    = $clog2(MAX_TEXT);
    localparam int CNT_W = $clog2(MAX_TEXT+1);
    localparam int SUM_W = CNT_W + 1;
    localparam int KI_W  = $clog2(MAX_KEY);
    localparam int W_W   = $clog2(MAX_KEY+1);

    // configuration registers
    logic [KEY_LOW_W-1:0]  key_low_reg;
    logic [KEY_HIGH_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_len_reg;

    // control state
    ctce_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  text_count_reg, text_count_next;
    logic              draining_reg, draining_next;
    logic [KI_W-1:0]   rank_reg, rank_next;
    logic [CNT_W-1:0]  row_base_reg, row_base_next;
    logic [W_W-1:0]    width_reg, width_next;
    logic [KI_W-1:0]   sweep_reg, sweep_next;
    logic              m_valid_reg, m_valid_next;

    // payload
    logic [KEY_W-1:0]  key_snap_reg;
    logic [KI_W-1:0]   order_reg [MAX_KEY];
    logic              hit_reg, hit_next;
    logic              last_reg, last_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic              s_accept;
    logic              is_load;
    logic              is_fetch;
    logic              close_msg;
    logic              snap_en;
    logic              order_wr;
    logic [W_W-1:0]    eff_len;

    key_char_t         key_chars [MAX_KEY];
    logic [KI_W-1:0]   sweep_rank;

    logic [KI_W-1:0]   cur_col;
    logic [SUM_W-1:0]  rd_idx;
    logic [SUM_W-1:0]  row_end_sum;
    logic              row_end;
    logic              rank_end;

    logic              ram_wr;
    logic              ram_rd;
    logic [7:0]        ram_rd_data;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data[KEY_LOW_W-1:0];
                REG_KEY_HIGH: key_high_reg <= cfg_data[KEY_HIGH_W-1:0];
                REG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, above the column limit clamps to it
    always_comb begin
        if (key_len_reg == '0) begin
            eff_len = W_W'(1);
        end else if (int'(key_len_reg) > MAX_KEY) begin
            eff_len = W_W'(MAX_KEY);
        end else begin
            eff_len = W_W'(key_len_reg);
        end
    end

    // ---------------------------------------------------------------- key rank
    for (genvar i = 0; i < MAX_KEY; i++) begin : g_key
        if (i < KEY_CHARS) begin : g_used
            assign key_chars[i] = key_snap_reg[8*i +: 8];
        end else begin : g_zero
            assign key_chars[i] = '0;
        end
    end

    ctce_rank #(
        .MAX_KEY (MAX_KEY)
    ) u_rank (
        .key_chars (key_chars),
        .key_len   (width_reg),
        .col       (sweep_reg),
        .rank      (sweep_rank)
    );

    // ---------------------------------------------------------------- read path
    assign cur_col     = order_reg[rank_reg];
    assign rd_idx      = SUM_W'(row_base_reg) + SUM_W'(cur_col);
    assign row_end_sum = SUM_W'(row_base_reg) + SUM_W'(width_reg);
    assign row_end     = row_end_sum > SUM_W'(text_count_reg);
    assign rank_end    = (W_W'(rank_reg) + W_W'(1)) == width_reg;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign is_load  = s_accept && (s_tuser == FUNC_LOAD);
    assign is_fetch = s_accept && (s_tuser == FUNC_FETCH);

    assign ram_wr    = is_load && !draining_reg && (text_count_reg < CNT_W'(MAX_TEXT));
    assign close_msg = is_load && !draining_reg && s_tlast;
    assign ram_rd    = is_fetch && draining_reg;

    ctce_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TEXT)
    ) u_text_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (text_count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (ram_rd),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next      = state_reg;
        text_count_next = text_count_reg;
        draining_next   = draining_reg;
        rank_next       = rank_reg;
        row_base_next   = row_base_reg;
        width_next      = width_reg;
        sweep_next      = sweep_reg;
        hit_next        = hit_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_user_next     = m_user_reg;
        snap_en         = 1'b0;
        order_wr        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (ram_wr) begin
                    text_count_next = text_count_reg + CNT_W'(1);
                end
                if (close_msg) begin
                    snap_en    = 1'b1;
                    width_next = eff_len;
                    sweep_next = '0;
                    state_next = ST_RANK;
                end
                if (is_fetch) begin
                    if (draining_reg) begin
                        hit_next  = rd_idx < SUM_W'(text_count_reg);
                        last_next = row_end && rank_end;
                        if (row_end && rank_end) begin
                            draining_next   = 1'b0;
                            text_count_next = '0;
                            rank_next       = '0;
                            row_base_next   = '0;
                        end else if (row_end) begin
                            row_base_next = '0;
                            rank_next     = rank_reg + KI_W'(1);
                        end else begin
                            row_base_next = row_end_sum[CNT_W-1:0] - CNT_W'(0);
                        end
                        state_next = ST_READ;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        m_last_next  = 1'b0;
                        m_user_next  = 1'b1;
                    end
                end
            end
            ST_RANK: begin
                order_wr = 1'b1;
                if ((W_W'(sweep_reg) + W_W'(1)) == width_reg) begin
                    draining_next = 1'b1;
                    rank_next     = '0;
                    row_base_next = '0;
                    state_next    = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + KI_W'(1);
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = hit_reg ? ram_rd_data : PAD_CHAR;
                m_last_next  = last_reg;
                m_user_next  = 1'b0;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            text_count_reg <= '0;
            draining_reg   <= 1'b0;
            rank_reg       <= '0;
            row_base_reg   <= '0;
            width_reg      <= W_W'(1);
            sweep_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            text_count_reg <= text_count_next;
            draining_reg   <= draining_next;
            rank_reg       <= rank_next;
            row_base_reg   <= row_base_next;
            width_reg      <= width_next;
            sweep_reg      <= sweep_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg    <= hit_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
        // key is frozen for the message at close
        if (snap_en) begin
            key_snap_reg <= {key_high_reg, key_low_reg};
        end
        if (order_wr) begin
            order_reg[sweep_rank] <= sweep_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for columnar_transposition_encrypt. Plaintext loads
// and ciphertext fetches go into the slave stream in random bursts, and key
// registers change between phases and in mid drain. A scoreboard class keeps its own copy of
// the grid, the column order and the read position, and predicts every
// fetch result. Each master transfer is compared against the oldest
// prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] cipher_byte;
    logic       final_byte;
    logic       nothing_left;
} cipher_result_t;

class cipher_scoreboard;
    localparam int TEXT_CAP = ctce_pkg::MAX_TEXT_DEF;
    localparam int KEY_CAP  = ctce_pkg::MAX_KEY_DEF;

    logic [7:0]     text_mem [TEXT_CAP];
    int unsigned    text_len;
    logic [3:0]     col_at_rank [KEY_CAP];
    int unsigned    rank_idx;
    int unsigned    row_idx;
    int unsigned    grid_cols;
    bit             drain_active;

    logic [63:0]    key_lo;
    logic [15:0]    key_hi;
    logic [3:0]     key_len;

    cipher_result_t expected_q[$];
    int unsigned    mismatches;
    int unsigned    checked;

    function new();
        for (int i = 0; i < TEXT_CAP; i++) text_mem[i] = 8'h00;
        for (int c = 0; c < KEY_CAP; c++) col_at_rank[c] = c[3:0];
        text_len     = 0;
        rank_idx     = 0;
        row_idx      = 0;
        grid_cols    = 1;
        drain_active = 1'b0;
        key_lo       = '0;
        key_hi       = '0;
        key_len      = 4'd1;
        mismatches   = 0;
        checked      = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function logic [7:0] key_char(int unsigned i);
        if (i < 8) return key_lo[8*i +: 8];
        if (i < 10) return key_hi[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    function void write_reg(logic [ctce_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
        if (idx == ctce_pkg::REG_KEY_LOW)
            key_lo = val;
        else if (idx == ctce_pkg::REG_KEY_HIGH)
            key_hi = val[15:0];
        else if (idx == ctce_pkg::REG_KEY_LEN)
            key_len = val[3:0];
    endfunction

    // stable ascending sort of the key characters, latched with the width
    function void close_message();
        int unsigned cols;
        int unsigned rank;
        cols = (key_len == 0) ? 1 : (key_len > KEY_CAP) ? KEY_CAP : key_len;
        for (int c = 0; c < KEY_CAP; c++) col_at_rank[c] = c[3:0];
        for (int c = 0; c < cols; c++) begin
            rank = 0;
            for (int j = 0; j < cols; j++) begin
                if (key_char(j) < key_char(c) || (key_char(j) == key_char(c) && j < c))
                    rank++;
            end
            col_at_rank[rank] = c[3:0];
        end
        grid_cols    = cols;
        rank_idx     = 0;
        row_idx      = 0;
        drain_active = 1'b1;
    endfunction

    function void note_input(logic func, logic [7:0] ch, logic eot);
        cipher_result_t res;
        int unsigned    rows;
        int unsigned    pos;
        bit             last;
        if (func == ctce_pkg::FUNC_LOAD) begin
            if (drain_active) return;
            if (text_len < TEXT_CAP) begin
                text_mem[text_len] = ch;
                text_len++;
            end
            if (eot) close_message();
            return;
        end
        if (!drain_active) begin
            res.cipher_byte  = 8'h00;
            res.final_byte   = 1'b0;
            res.nothing_left = 1'b1;
            expected_q.push_back(res);
            return;
        end
        rows = text_len / grid_cols + 1;
        pos  = row_idx * grid_cols + col_at_rank[rank_idx];
        last = (rank_idx + 1 >= grid_cols) && (row_idx + 1 >= rows);
        res.cipher_byte  = (pos < text_len) ? text_mem[pos] : ctce_pkg::PAD_CHAR;
        res.final_byte   = last;
        res.nothing_left = 1'b0;
        expected_q.push_back(res);
        if (last) begin
            drain_active = 1'b0;
            text_len     = 0;
            rank_idx     = 0;
            row_idx      = 0;
        end else if (row_idx + 1 >= rows) begin
            row_idx = 0;
            rank_idx++;
        end else begin
            row_idx++;
        end
    endfunction

    function void check_result(logic [7:0] ch, logic fin, logic empty);
        cipher_result_t want;
        checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected cipher result %0d: byte %02h last %0b empty %0b",
                         checked, ch, fin, empty);
            return;
        end
        want = expected_q.pop_front();
        if (ch !== want.cipher_byte || fin !== want.final_byte
                || empty !== want.nothing_left) begin
            mismatches++;
            if (mismatches <= 10)
                $display("cipher result %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                         checked, want.cipher_byte, want.final_byte, want.nothing_left,
                         ch, fin, empty);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctce_pkg::*;

    localparam int TEXT_CAP     = MAX_TEXT_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int IDLE_SETTLE  = 16;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 600_000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;
    typedef enum int {KEY_RANDOM, KEY_FEW, KEY_SAME, KEY_RISING, KEY_FALLING,
                      KEY_EXTREME} key_style_t;

    logic                   aclk;
    logic                   aresetn;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // [7:0] plain_byte
    logic                   s_tuser;    // [0] func
    logic                   s_tlast;

    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;    // [7:0] cipher_byte
    logic                   m_tuser;    // [0] nothing_left
    logic                   m_tlast;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cipher_scoreboard sb = new();

    int burst_left  = 0;
    int key_cols    = 1;
    int items_done  = 0;
    int hold_asks   = 0;
    int cycle_count = 0;

    columnar_transposition_encrypt dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("columnar_transposition_encrypt: mismatch");
                $finish;
            end
        end
    end

    // transfers seen at the edge, in the order results then inputs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    // receiver: changing stall patterns, plus a long hold-off when asked
    initial begin
        rx_mode_t    mode;
        int          mode_left;
        int          hold_left;
        int          holds_served;
        logic [15:0] pattern;
        int          pat_bit;
        mode         = RX_OPEN;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        pattern      = 16'hFFFF;
        pat_bit      = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_asks != holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                    pattern   = 16'($urandom) | 16'h0001;
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                    default: begin
                        m_tready <= pattern[pat_bit];
                        pat_bit = (pat_bit + 1) % 16;
                    end
                endcase
            end
        end
    end

    task automatic send_item(input logic func, input logic [7:0] ch, input logic eot);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= ch;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        items_done++;
    endtask

    // byte and end mark are don't-care on a fetch, so they stay random
    task automatic fetch(input int n);
        repeat (n) send_item(FUNC_FETCH, 8'($urandom), 1'($urandom));
    endtask

    // a load offered while ciphertext is still pending has no effect
    task automatic send_ignored_load();
        send_item(FUNC_LOAD, 8'($urandom), 1'($urandom));
        items_done--;
    endtask

    task automatic load_message(input int n);
        logic [7:0] ch;
        int         pick;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) fetch(1);
            pick = $urandom_range(0, 9);
            ch = (pick == 0) ? PAD_CHAR : (pick == 1) ? 8'h00 : (pick == 2) ? 8'hFF
                                        : 8'($urandom);
            send_item(FUNC_LOAD, ch, i == n - 1);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic reconfigure(input logic [63:0] lo, input logic [15:0] hi,
                               input logic [3:0] len, input logic [2:0] which);
        logic [CFG_INDEX_W-1:0] regs [3];
        logic [CFG_INDEX_W-1:0] code;
        bit                     backwards;
        int                     r;
        regs      = '{REG_KEY_LOW, REG_KEY_HIGH, REG_KEY_LEN};
        backwards = 1'($urandom_range(0, 1));
        wait_idle();
        for (int k = 0; k < 3; k++) begin
            r    = backwards ? 2 - k : k;
            code = regs[r];
            if (which[r])
                write_reg(code, (code == REG_KEY_LOW)  ? lo
                              : (code == REG_KEY_HIGH) ? {48'h0, hi} : {60'h0, len});
        end
        cfg_valid <= 1'b0;
        if (which[2])
            key_cols = (len == 0) ? 1 : (len > MAX_KEY_DEF) ? MAX_KEY_DEF : len;
    endtask

    function automatic logic [79:0] make_key(key_style_t style);
        logic [79:0] k;
        logic [7:0]  base;
        base = 8'($urandom);
        for (int i = 0; i < 10; i++) begin
            case (style)
                KEY_FEW:     k[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 2));
                KEY_SAME:    k[8*i +: 8] = base;
                KEY_RISING:  k[8*i +: 8] = base + 8'(i);
                KEY_FALLING: k[8*i +: 8] = base - 8'(i);
                KEY_EXTREME: k[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:     k[8*i +: 8] = 8'($urandom);
            endcase
        end
        return k;
    endfunction

    task automatic random_key();
        logic [79:0] k;
        logic [3:0]  len;
        logic [2:0]  which;
        int          pick;
        k    = make_key(key_style_t'($urandom_range(0, 5)));
        pick = $urandom_range(0, 9);
        len  = (pick == 0) ? 4'd0 : (pick == 1) ? 4'($urandom_range(11, 15))
             : (pick == 2) ? 4'd10 : (pick == 3) ? 4'd1 : 4'($urandom_range(2, 10));
        which = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 7)) : 3'b111;
        reconfigure(k[63:0], k[79:64], len, which);
    endtask

    initial begin
        int n;
        int total;
        int k;
        int phase;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= FUNC_LOAD;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_KEY_LOW;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fetch on an empty block, then a one-column grid
        fetch(1);
        send_item(FUNC_LOAD, 8'hFF, 1'b1);
        fetch(3);
        // oversized length counts as ten columns, key has ties and extremes
        reconfigure(64'h4100_FF41_7A00_6141, 16'hFF41, 4'd15, 3'b111);
        send_item(FUNC_LOAD, 8'h00, 1'b0);
        send_item(FUNC_LOAD, PAD_CHAR, 1'b0);
        send_item(FUNC_LOAD, 8'h80, 1'b1);
        fetch(4);
        send_ignored_load();
        // key change mid drain must not touch the pending ciphertext
        reconfigure(64'h0123_4567_89AB_CDEF, 16'h0000, 4'd0, 3'b101);
        fetch(7);
        send_item(FUNC_LOAD, 8'h7F, 1'b0);
        send_item(FUNC_LOAD, 8'h01, 1'b1);
        fetch(3);

        items_done = 0;
        phase = 0;
        while (items_done < RANDOM_ITEMS) begin
            phase++;
            if (phase == 1 || $urandom_range(0, 2) == 0) random_key();
            if ($urandom_range(0, 9) == 0) fetch($urandom_range(1, 4));
            k = $urandom_range(0, 29);
            n = (phase == 1) ? 135 : (phase == 2) ? TEXT_CAP : (phase == 3) ? TEXT_CAP - 1
              : (k == 0) ? $urandom_range(120, 140)
              : (k < 5) ? key_cols * $urandom_range(1, 4) : $urandom_range(1, 24);
            load_message(n);
            total = ((n > TEXT_CAP ? TEXT_CAP : n) / key_cols + 1) * key_cols;
            // stall the receiver while a long run of fetches is offered
            if (phase == 1 || phase == 20) hold_asks <= hold_asks + 1;
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(0, total - 1);
                fetch(k);
                repeat ($urandom_range(1, 3)) send_ignored_load();
                if ($urandom_range(0, 1)) random_key();
                fetch(total - k);
            end else begin
                fetch(total);
            end
            if ($urandom_range(0, 3) == 0) fetch(1);
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("columnar_transposition_encrypt: match");
        else
            $display("columnar_transposition_encrypt: mismatch");
        $finish;
    end
endmodule
